@@ rtl/chunk_frustum_culling_top_defines.svh @@
// Assertion macros for the chunk frustum culling block.
// Used by the port checker; no other dependencies.
`ifndef CHUNK_FRUSTUM_CULLING_TOP_DEFINES_SVH
`define CHUNK_FRUSTUM_CULLING_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define CFC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define CFC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cfc_pkg.sv @@
// Shared types and constants for the chunk frustum culling block.
// No dependencies; imported by the top level and its port checker.
package cfc_pkg;

   localparam int CHUNK_WIDTH_DEF     = 16;
   localparam int SUBCHUNK_HEIGHT_DEF = 16;
   localparam int SUBCHUNK_COUNT_DEF  = 8;
   localparam int COLUMN_HEIGHT_DEF   = 128;

   localparam int PLANES  = 6;
   localparam int PIDX_W  = 3;
   localparam int COEF_W  = 32;
   localparam int CHUNK_W = 16;
   localparam int MASK_W  = 8;

   // request word layout, lowest bit first
   localparam int PIX_LSB  = 0;
   localparam int CA_LSB   = PIX_LSB + PIDX_W;
   localparam int CB_LSB   = CA_LSB + COEF_W;
   localparam int CC_LSB   = CB_LSB + COEF_W;
   localparam int CD_LSB   = CC_LSB + COEF_W;
   localparam int CX_LSB   = CD_LSB + COEF_W;
   localparam int CZ_LSB   = CX_LSB + CHUNK_W;
   localparam int MSK_LSB  = CZ_LSB + CHUNK_W;
   localparam int REQ_BITS = MSK_LSB + MASK_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 1;

   // response word layout
   localparam int VIS_LSB  = 0;
   localparam int COL_BIT  = VIS_LSB + MASK_W;
   localparam int RSP_TDATA_W = ((COL_BIT + 1 + 7) / 8) * 8;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MX   = 7'b0000010,
      ST_MZ   = 7'b0000100,
      ST_AXZ  = 7'b0001000,
      ST_MY   = 7'b0010000,
      ST_CMP  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

endpackage

@@ rtl/chunk_frustum_culling_top.sv @@
// A plane load gives no response word. A column test computes, for each plane in turn, the
// x/z terms on the shared multiplier (ST_MX, ST_MZ, ST_AXZ), then runs ST_MY and ST_CMP per
// plane for each box (column, then each occupied subchunk), leaving a box at its first failing
// plane.
// Throughput: one test at a time; req_tready is high only in ST_IDLE.
// Reset: synchronous, clears control and response valid; planes are undefined until loaded.
module chunk_frustum_culling_top #(
   parameter int CHUNK_WIDTH     = cfc_pkg::CHUNK_WIDTH_DEF,
   parameter int SUBCHUNK_HEIGHT = cfc_pkg::SUBCHUNK_HEIGHT_DEF,
   parameter int SUBCHUNK_COUNT  = cfc_pkg::SUBCHUNK_COUNT_DEF,
   parameter int COLUMN_HEIGHT   = cfc_pkg::COLUMN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // plane_index, coef_a, coef_b, coef_c, coef_d, chunk_x, chunk_z, subchunk_mask
   input  logic [cfc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op
   input  logic [cfc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // visible_mask, column_visible
   output logic [cfc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import cfc_pkg::*;

   localparam int CRD_W = 18 + $clog2(CHUNK_WIDTH);
   localparam int PRD_W = COEF_W + CRD_W;
   localparam int SUM_W = PRD_W + 2;

   logic signed [COEF_W-1:0] plane_x_coef_ff [PLANES];
   logic signed [COEF_W-1:0] plane_y_coef_ff [PLANES];
   logic signed [COEF_W-1:0] plane_z_coef_ff [PLANES];
   logic signed [COEF_W-1:0] plane_offset_ff [PLANES];
   logic signed [SUM_W-1:0]  part_ff [PLANES];

   state_type               state_ff, state_in;
   logic [PIDX_W-1:0]       plane_ff, plane_in;
   logic signed [CRD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, z0_ff, z0_in, z1_ff, z1_in;
   logic [MASK_W-1:0]       pend_ff, pend_in, vis_ff, vis_in;
   logic [2:0]              sub_ff, sub_in;
   logic                    col_phase_ff, col_phase_in, col_ff, col_in;
   logic signed [SUM_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                    accept, part_we, sum_neg, pass_box;
   logic [PIDX_W-1:0]       f_pidx;
   logic signed [CHUNK_W-1:0] f_cx, f_cz;
   logic signed [CRD_W-1:0] cx_ext, cz_ext, y0, y1, sub_y0;
   logic signed [COEF_W-1:0] mul_coef;
   logic signed [CRD_W-1:0] mul_crd;
   logic signed [PRD_W-1:0] mul_prd;
   logic signed [SUM_W-1:0] sum;
   logic [2:0]              nxt_idx;
   logic                    last_plane;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign f_pidx = req_tdata[PIX_LSB +: PIDX_W];
   assign f_cx   = req_tdata[CX_LSB +: CHUNK_W];
   assign f_cz   = req_tdata[CZ_LSB +: CHUNK_W];
   assign cx_ext = CRD_W'(f_cx);
   assign cz_ext = CRD_W'(f_cz);

   assign sub_y0 = CRD_W'(sub_ff) * CRD_W'(SUBCHUNK_HEIGHT);
   assign y0     = col_phase_ff ? CRD_W'(0) : sub_y0;
   assign y1     = col_phase_ff ? CRD_W'(COLUMN_HEIGHT) : sub_y0 + CRD_W'(SUBCHUNK_HEIGHT);

   assign last_plane = (plane_ff == PIDX_W'(PLANES - 1));
   assign sum        = part_ff[plane_ff] + prod_ff;
   assign sum_neg    = sum[SUM_W-1];
   assign pass_box   = !sum_neg;
   assign part_we    = (state_ff == ST_AXZ);

   // shared multiplier
   always_comb begin
      mul_coef = plane_y_coef_ff[plane_ff];
      mul_crd  = plane_y_coef_ff[plane_ff][COEF_W-1] ? y0 : y1;
      if (state_ff == ST_MX) begin
         mul_coef = plane_x_coef_ff[plane_ff];
         mul_crd  = plane_x_coef_ff[plane_ff][COEF_W-1] ? x0_ff : x1_ff;
      end else if (state_ff == ST_MZ) begin
         mul_coef = plane_z_coef_ff[plane_ff];
         mul_crd  = plane_z_coef_ff[plane_ff][COEF_W-1] ? z0_ff : z1_ff;
      end
   end

   assign mul_prd = mul_coef * mul_crd;

   always_comb begin
      nxt_idx = '0;
      for (int k = MASK_W - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            nxt_idx = 3'(k);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      plane_in      = plane_ff;
      x0_in         = x0_ff;
      x1_in         = x1_ff;
      z0_in         = z0_ff;
      z1_in         = z1_ff;
      pend_in       = pend_ff;
      vis_in        = vis_ff;
      sub_in        = sub_ff;
      col_phase_in  = col_phase_ff;
      col_in        = col_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser[0] == OP_TEST) begin
               x0_in = cx_ext * CRD_W'(CHUNK_WIDTH);
               x1_in = cx_ext * CRD_W'(CHUNK_WIDTH) + CRD_W'(CHUNK_WIDTH);
               z0_in = cz_ext * CRD_W'(CHUNK_WIDTH);
               z1_in = cz_ext * CRD_W'(CHUNK_WIDTH) + CRD_W'(CHUNK_WIDTH);
               for (int k = 0; k < MASK_W; k++) begin
                  pend_in[k] = req_tdata[MSK_LSB + k] && (k < SUBCHUNK_COUNT);
               end
               vis_in       = '0;
               col_in       = 1'b0;
               col_phase_in = 1'b1;
               sub_in       = '0;
               plane_in     = '0;
               state_in     = ST_MX;
            end
         end
         ST_MX: begin
            prod_in  = SUM_W'(mul_prd);
            state_in = ST_MZ;
         end
         ST_MZ: begin
            acc_in   = prod_ff + SUM_W'(plane_offset_ff[plane_ff]);
            prod_in  = SUM_W'(mul_prd);
            state_in = ST_AXZ;
         end
         ST_AXZ: begin
            if (last_plane) begin
               plane_in = '0;
               state_in = ST_MY;
            end else begin
               plane_in = plane_ff + 1'b1;
               state_in = ST_MX;
            end
         end
         ST_MY: begin
            prod_in  = SUM_W'(mul_prd);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (pass_box && !last_plane) begin
               plane_in = plane_ff + 1'b1;
               state_in = ST_MY;
            end else begin
               // box finished: record verdict, pick the next occupied subchunk
               if (col_phase_ff) begin
                  col_in = pass_box;
               end else begin
                  vis_in[sub_ff] = pass_box;
               end
               plane_in     = '0;
               col_phase_in = 1'b0;
               if ((col_phase_ff && !pass_box) || pend_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  sub_in           = nxt_idx;
                  pend_in[nxt_idx] = 1'b0;
                  state_in         = ST_MY;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[VIS_LSB +: MASK_W] = vis_ff;
               rsp_tdata_in[COL_BIT]           = col_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff     <= plane_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      z0_ff        <= z0_in;
      z1_ff        <= z1_in;
      pend_ff      <= pend_in;
      vis_ff       <= vis_in;
      sub_ff       <= sub_in;
      col_phase_ff <= col_phase_in;
      col_ff       <= col_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // plane store; drop loads beyond the last plane
   always_ff @(posedge clock) begin
      if (accept && req_tuser[0] == OP_LOAD && f_pidx < PIDX_W'(PLANES)) begin
         plane_x_coef_ff[f_pidx] <= req_tdata[CA_LSB +: COEF_W];
         plane_y_coef_ff[f_pidx] <= req_tdata[CB_LSB +: COEF_W];
         plane_z_coef_ff[f_pidx] <= req_tdata[CC_LSB +: COEF_W];
         plane_offset_ff[f_pidx] <= req_tdata[CD_LSB +: COEF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (part_we) begin
         part_ff[plane_ff] <= acc_ff + prod_ff;
      end
   end

endmodule

@@ rtl/cfc_checker.sv @@
// Port checker for the chunk frustum culling block, bound to the top level.
// Depends on cfc_pkg and chunk_frustum_culling_top_defines.svh.
`include "chunk_frustum_culling_top_defines.svh"

module cfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [cfc_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cfc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cfc_pkg::*;

   `CFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word dropped or changed while stalled")
   `CFC_ASSERT_IMP(a_mask_needs_col, clock, reset, rsp_tvalid, rsp_tdata[COL_BIT] || rsp_tdata[VIS_LSB +: MASK_W] == '0, "visible subchunk in a culled column")
   `CFC_ASSERT_NXT(a_busy_after_test, clock, reset, req_tvalid && req_tready && req_tuser[0] == OP_TEST, !req_tready, "new word taken while a test runs")
   `CFC_ASSERT_IMP(a_no_rsp_after_reset, clock, 1'b0, $past(reset) && !reset, !rsp_tvalid, "response word present just after reset")

endmodule

bind chunk_frustum_culling_top cfc_checker u_cfc_checker (.*);

@@ tb/sv/tb_chunk_frustum_culling_top.sv @@
// Self-checking bench for chunk_frustum_culling_top: streams plane loads and column tests,
// predicts each visibility word and compares it with the response stream.
// Depends on cfc_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb_chunk_frustum_culling_top;
   import cfc_pkg::*;

   localparam int ITEMS       = 2000;
   localparam int HOLD_CYCLES = 600;
   localparam int ONE         = 65536;

   typedef struct {
      logic                     op;
      logic [PIDX_W-1:0]        plane_index;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
      logic signed [COEF_W-1:0] coef_d;
      logic signed [CHUNK_W-1:0] chunk_x;
      logic signed [CHUNK_W-1:0] chunk_z;
      logic [MASK_W-1:0]        subchunk_mask;
   } column_word_type;

   typedef struct {
      logic [MASK_W-1:0] visible_mask;
      logic              column_visible;
   } cull_verdict_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   chunk_frustum_culling_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   logic signed [COEF_W-1:0] plane_a [PLANES];
   logic signed [COEF_W-1:0] plane_b [PLANES];
   logic signed [COEF_W-1:0] plane_c [PLANES];
   logic signed [COEF_W-1:0] plane_d [PLANES];

   column_word_type  pending_words [$];
   cull_verdict_type expected_culls [$];
   column_word_type  on_bus;
   cull_verdict_type want;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   int            mismatches  = 0;
   int            counted     = 0;
   logic          hold_arm    = 1'b0;
   int            hold_left   = 0;

   function automatic bit box_passes(longint x0, longint x1, longint y0, longint y1,
                                     longint z0, longint z1);
      longint sum;
      for (int i = 0; i < PLANES; i++) begin
         sum = longint'(plane_a[i]) * ((plane_a[i] >= 0) ? x1 : x0)
             + longint'(plane_b[i]) * ((plane_b[i] >= 0) ? y1 : y0)
             + longint'(plane_c[i]) * ((plane_c[i] >= 0) ? z1 : z0)
             + longint'(plane_d[i]);
         if (sum < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic cull_verdict_type cull_column(column_word_type w);
      cull_verdict_type v;
      longint        x0, x1, z0, z1;
      x0 = longint'(w.chunk_x) * CHUNK_WIDTH_DEF;
      x1 = x0 + CHUNK_WIDTH_DEF;
      z0 = longint'(w.chunk_z) * CHUNK_WIDTH_DEF;
      z1 = z0 + CHUNK_WIDTH_DEF;
      v.visible_mask   = '0;
      v.column_visible = box_passes(x0, x1, 0, COLUMN_HEIGHT_DEF, z0, z1);
      if (v.column_visible) begin
         for (int s = 0; s < SUBCHUNK_COUNT_DEF && s < MASK_W; s++) begin
            if (w.subchunk_mask[s] && box_passes(x0, x1, s * SUBCHUNK_HEIGHT_DEF,
                                                 (s + 1) * SUBCHUNK_HEIGHT_DEF, z0, z1))
               v.visible_mask[s] = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic logic signed [COEF_W-1:0] small_coef();
      if ($urandom_range(4) == 0) return '0;
      return $urandom_range(1 << 18) - (1 << 17);
   endfunction

   task automatic push_load(logic [PIDX_W-1:0] idx, logic signed [COEF_W-1:0] a,
                            logic signed [COEF_W-1:0] b, logic signed [COEF_W-1:0] c,
                            logic signed [COEF_W-1:0] d);
      column_word_type w;
      w.op            = OP_LOAD;
      w.plane_index   = idx;
      w.coef_a        = a;
      w.coef_b        = b;
      w.coef_c        = c;
      w.coef_d        = d;
      w.chunk_x       = CHUNK_W'($urandom);
      w.chunk_z       = CHUNK_W'($urandom);
      w.subchunk_mask = MASK_W'($urandom);
      pending_words.insert(pending_words.size(), w);
      if (idx < PLANES) counted++;
   endtask

   task automatic push_test(logic signed [CHUNK_W-1:0] x, logic signed [CHUNK_W-1:0] z,
                            logic [MASK_W-1:0] mask);
      column_word_type w;
      w.op            = OP_TEST;
      w.plane_index   = PIDX_W'($urandom);
      w.coef_a        = $urandom;
      w.coef_b        = $urandom;
      w.coef_c        = $urandom;
      w.coef_d        = $urandom;
      w.chunk_x       = x;
      w.chunk_z       = z;
      w.subchunk_mask = mask;
      pending_words.insert(pending_words.size(), w);
      counted++;
   endtask

   // planes with a common point near a random centre on their inner side, then columns mostly around it
   task automatic push_scene();
      int                       cx, cz, n;
      longint                   px, py, pz, acc;
      logic signed [COEF_W-1:0] a, b, c;
      bit                       noise;
      cx    = $urandom_range(200) - 100;
      cz    = $urandom_range(200) - 100;
      noise = ($urandom_range(7) == 0);
      px    = longint'(cx) * CHUNK_WIDTH_DEF + $urandom_range(CHUNK_WIDTH_DEF - 1);
      py    = $urandom_range(COLUMN_HEIGHT_DEF);
      pz    = longint'(cz) * CHUNK_WIDTH_DEF + $urandom_range(CHUNK_WIDTH_DEF - 1);
      for (int i = 0; i < PLANES; i++) begin
         if ($urandom_range(9) == 0)
            push_load(PIDX_W'(PLANES + $urandom_range(1)), $urandom, $urandom, $urandom,
                      $urandom);
         if (noise) begin
            push_load(PIDX_W'(i), $urandom, $urandom, $urandom, $urandom);
         end else begin
            a   = small_coef();
            b   = small_coef();
            c   = small_coef();
            acc = longint'($urandom_range(1 << 22))
                - (longint'(a) * px + longint'(b) * py + longint'(c) * pz);
            push_load(PIDX_W'(i), a, b, c, 32'(acc));
         end
      end
      n = $urandom_range(35, 15);
      repeat (n) begin
         if ($urandom_range(9) == 0)
            push_test(CHUNK_W'($urandom), CHUNK_W'($urandom), MASK_W'($urandom));
         else
            push_test(CHUNK_W'(cx + $urandom_range(12) - 6),
                      CHUNK_W'(cz + $urandom_range(12) - 6),
                      ($urandom_range(3) == 0) ? 8'hff : 8'($urandom));
      end
   endtask

   // driver: hold the word until taken, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (on_bus.op == OP_LOAD) begin
               if (on_bus.plane_index < PLANES) begin
                  plane_a[on_bus.plane_index] = on_bus.coef_a;
                  plane_b[on_bus.plane_index] = on_bus.coef_b;
                  plane_c[on_bus.plane_index] = on_bus.coef_c;
                  plane_d[on_bus.plane_index] = on_bus.coef_d;
               end
            end else begin
               expected_culls.insert(expected_culls.size(), cull_column(on_bus));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               on_bus = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'({on_bus.subchunk_mask, on_bus.chunk_z,
                                           on_bus.chunk_x, on_bus.coef_d, on_bus.coef_c,
                                           on_bus.coef_b, on_bus.coef_a,
                                           on_bus.plane_index});
               req_tuser  <= on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_arm)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_culls.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word %h at %0t", rsp_tdata, $time);
            end else begin
               want = expected_culls.pop_front();
               if (rsp_tdata[VIS_LSB +: MASK_W] !== want.visible_mask ||
                   rsp_tdata[COL_BIT] !== want.column_visible) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: visible_mask exp %h got %h, %s %0d got %0d",
                              $time, want.visible_mask, rsp_tdata[VIS_LSB +: MASK_W],
                              "column_visible exp", want.column_visible, rsp_tdata[COL_BIT]);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 58 : 0;
         rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 36 : 0;
         if (phase == 0) begin
            // axis-aligned frustum: |x|,|z| <= 64, 40 <= y <= 72
            push_load(0,  ONE, 0, 0, 64 * ONE);
            push_load(1, -ONE, 0, 0, 64 * ONE);
            push_load(2, 0, 0,  ONE, 64 * ONE);
            push_load(3, 0, 0, -ONE, 64 * ONE);
            push_load(4, 0, -ONE, 0, 72 * ONE);
            push_load(5, 0,  ONE, 0, -40 * ONE);
            push_test(0, 0, 8'hff);
            push_test(-4, 3, 8'h55);
            push_test(4, 0, 8'hff);
            push_test(5, 0, 8'hff);
            push_test(-5, 0, 8'hff);
            push_test(-6, 0, 8'hff);
            push_test(0, 4, 8'hff);
            push_test(0, 5, 8'hff);
            push_test(0, 0, 8'h00);
            push_test(16'sh7fff, 16'sh8000, 8'hff);
            push_test(16'sh8000, 16'sh7fff, 8'hff);
            push_load(6, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
            push_load(7, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
            push_test(0, 0, 8'hff);
            push_load(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
            push_test(16'sh8000, 16'sh8000, 8'hff);
            push_test(16'sh7fff, 16'sh7fff, 8'hff);
            push_test(0, 0, 8'hff);
         end
         while (counted < (phase + 1) * ITEMS / 3) push_scene();
         if (phase == 2) begin
            hold_arm = 1'b1;
            @(negedge clock);
            hold_arm = 1'b0;
         end
         while (pending_words.size() != 0 || req_tvalid || expected_culls.size() != 0)
            @(negedge clock);
      end
      repeat (200) @(negedge clock);
      if (mismatches == 0 && expected_culls.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
